/* hdl/wsc_pkg.sv */
package wsc_pkg;

    // command codes carried in s_tuser
    localparam logic [1:0] CMD_ACCUM = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_EXPOSURE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STATUS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_POS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PIX_COUNT  = 3'd4;
    localparam int CFG_DATA_W = 16;

    localparam int IN_DATA_W  = 160;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 184;

    // signed destination index: 14-bit index plus 15-bit shift
    localparam int DST_W = 17;

    // readout math stages after the input register
    localparam int RD_STAGES = 28;

    // result queue depth, larger than the read round trip
    localparam int FIFO_DEPTH = 64;
    localparam int FIFO_AW    = 6;
    localparam int CREDIT_W   = 7;

    typedef struct packed {
        logic [15:0]        exposure;
        logic signed [14:0] shift;
        logic signed [7:0]  status;
        logic               accept_pos;
        logic [14:0]        pixel_count;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [13:0]        idx;
        logic signed [23:0] flux;
        logic [15:0]        err;
        logic [7:0]         qual;
        logic [23:0]        cnt;
        logic signed [23:0] wts;
        logic signed [23:0] bkg;
    } item_t;

    // one accumulator entry
    typedef struct packed {
        logic [23:0] exp_sum;
        logic [47:0] flux_sum;
        logic [63:0] var_sum;
        logic [31:0] cnt_sum;
        logic [31:0] wts_sum;
        logic [31:0] bkg_sum;
        logic [31:0] qual_sum;
    } mem_t;

    typedef struct packed {
        logic [13:0] idx;
        mem_t        sums;
    } rd_in_t;

    typedef struct packed {
        logic [13:0] out_index;
        logic [23:0] mean_flux;
        logic [15:0] mean_error;
        logic [7:0]  mean_quality;
        logic [31:0] total_counts;
        logic [31:0] total_weights;
        logic [31:0] total_background;
        logic [23:0] total_exposure;
    } out_t;

endpackage

/* hdl/weighted_spectrum_coadd.sv */
// Exposure-weighted co-adder of spectra into a per-pixel sum memory.
// s_ channel: one command per transfer. s_tuser selects accumulate, read
// out or clear; s_tdata carries the pixel index and the pixel values.
// Accumulate adds exposure-weighted sums at index + pixel_shift, clear
// zeroes one pixel, read returns one result transfer on the m_ channel
// with the means and raw totals of that pixel. Other commands give none.
// cfg_ channel: register writes (exposure, shift, status, status policy,
// pixel count), always ready; write only while the block is idle.
// Throughput: one command per cycle, any mix, while s_tready is high. The
// sum memory is read from the stage 2 address and written back from
// stage 3; a write is forwarded to the next command, so back-to-back hits
// on a pixel are fine. A read passes the square root and divider pipeline
// (28 stages) and a 64-entry result queue on its way to m_tvalid.
// Results come out in command order.
// Reset: a clearing pass writes zeros through the sum memory, one pixel a
// cycle, over all NUM_PIXELS entries; s_tready is low until it ends.
// Stall on m_: the result queue keeps taking results; s_tready drops only
// once 64 read commands are outstanding.
module weighted_spectrum_coadd #(
    parameter int NUM_PIXELS = 16384
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pixel_index, flux, error, quality, counts, weights, background, zero pad
    input  logic [wsc_pkg::IN_DATA_W-1:0]       s_tdata,
    // command
    input  logic [wsc_pkg::IN_USER_W-1:0]       s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_index, mean_flux, mean_error, mean_quality, total_counts,
    // total_weights, total_background, total_exposure, zero pad
    output logic [wsc_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wsc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wsc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import wsc_pkg::*;

    cfg_t   cfg_reg;
    item_t  item;
    logic   s_fire;
    logic   m_fire;
    logic   busy;

    logic   acc_rd_valid;
    rd_in_t acc_rd_data;
    logic   res_valid;
    out_t   res_data;

    // read commands accepted and not yet delivered
    logic [CREDIT_W-1:0] credit_reg;
    logic [CREDIT_W-1:0] credit_next;

    // result queue in memory plus a two-entry output stage
    logic [FIFO_AW-1:0]  fifo_wptr_reg;
    logic [FIFO_AW-1:0]  fifo_rptr_reg;
    logic [CREDIT_W-1:0] fifo_cnt_reg;
    logic [CREDIT_W-1:0] fifo_cnt_next;
    logic                fifo_re;
    out_t                fifo_rdata;
    logic                rd_pend_reg;
    out_t                oq_reg [2];
    logic                oq_wptr_reg;
    logic                oq_rptr_reg;
    logic [1:0]          oq_cnt_reg;
    logic [1:0]          oq_cnt_next;
    out_t                head;

    assign s_fire    = s_tvalid && s_tready;
    assign m_fire    = m_tvalid && m_tready;
    assign cfg_ready = 1'b1;
    assign s_tready  = !busy && (credit_reg < CREDIT_W'(FIFO_DEPTH));

    assign item.cmd  = s_tuser;
    assign item.idx  = s_tdata[13:0];
    assign item.flux = s_tdata[37:14];
    assign item.err  = s_tdata[53:38];
    assign item.qual = s_tdata[61:54];
    assign item.cnt  = s_tdata[85:62];
    assign item.wts  = s_tdata[109:86];
    assign item.bkg  = s_tdata[133:110];

    // ---- configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.exposure    <= '0;
            cfg_reg.shift       <= '0;
            cfg_reg.status      <= '0;
            cfg_reg.accept_pos  <= 1'b0;
            cfg_reg.pixel_count <= 15'd16384;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_EXPOSURE:   cfg_reg.exposure    <= cfg_data;
                REG_SHIFT:      cfg_reg.shift       <= cfg_data[14:0];
                REG_STATUS:     cfg_reg.status      <= cfg_data[7:0];
                REG_ACCEPT_POS: cfg_reg.accept_pos  <= cfg_data[0];
                REG_PIX_COUNT:  cfg_reg.pixel_count <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    wsc_accum #(
        .NUM_PIXELS (NUM_PIXELS)
    ) u_accum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_fire),
        .in_item  (item),
        .cfg      (cfg_reg),
        .busy     (busy),
        .rd_valid (acc_rd_valid),
        .rd_data  (acc_rd_data)
    );

    wsc_readout u_readout (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (acc_rd_valid),
        .in_data   (acc_rd_data),
        .out_valid (res_valid),
        .out_data  (res_data)
    );

    wsc_ram #(
        .WIDTH ($bits(out_t)),
        .DEPTH (FIFO_DEPTH)
    ) u_res_fifo (
        .aclk  (aclk),
        .we    (res_valid),
        .waddr (fifo_wptr_reg),
        .wdata (res_data),
        .raddr (fifo_rptr_reg),
        .rdata (fifo_rdata)
    );

    // pull from the queue while the output stage has a free slot
    always_comb begin
        fifo_re = (fifo_cnt_reg != '0)
                  && (((oq_cnt_reg + {1'b0, rd_pend_reg}) != 2'd2) || m_fire);
        fifo_cnt_next = fifo_cnt_reg + CREDIT_W'(res_valid) - CREDIT_W'(fifo_re);
        oq_cnt_next   = oq_cnt_reg + 2'(rd_pend_reg) - 2'(m_fire);
        credit_next   = credit_reg + CREDIT_W'(s_fire && (item.cmd == CMD_READ))
                        - CREDIT_W'(m_fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg    <= '0;
            fifo_wptr_reg <= '0;
            fifo_rptr_reg <= '0;
            fifo_cnt_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            oq_wptr_reg   <= 1'b0;
            oq_rptr_reg   <= 1'b0;
            oq_cnt_reg    <= '0;
        end else begin
            credit_reg   <= credit_next;
            fifo_cnt_reg <= fifo_cnt_next;
            oq_cnt_reg   <= oq_cnt_next;
            rd_pend_reg  <= fifo_re;
            if (res_valid) begin
                fifo_wptr_reg <= fifo_wptr_reg + FIFO_AW'(1);
            end
            if (fifo_re) begin
                fifo_rptr_reg <= fifo_rptr_reg + FIFO_AW'(1);
            end
            if (rd_pend_reg) begin
                oq_wptr_reg <= !oq_wptr_reg;
            end
            if (m_fire) begin
                oq_rptr_reg <= !oq_rptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_pend_reg) begin
            oq_reg[oq_wptr_reg] <= fifo_rdata;
        end
    end

    assign head     = oq_reg[oq_rptr_reg];
    assign m_tvalid = oq_cnt_reg != 2'd0;
    assign m_tdata  = {2'b00, head.total_exposure, head.total_background,
                       head.total_weights, head.total_counts, head.mean_quality,
                       head.mean_error, head.mean_flux, head.out_index};

    // ---- checks
    a_fifo_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (fifo_cnt_reg != CREDIT_W'(FIFO_DEPTH)))
        else $error("result queue written while full");

    a_out_has_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (credit_reg != '0))
        else $error("result offered with no read outstanding");

    a_out_stage_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> (oq_cnt_reg != 2'd2) || $past(m_fire))
        else $error("output stage overrun");

endmodule

/* hdl/wsc_ram.sv */
module wsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first: a read of the entry being written returns the old data
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/wsc_accum.sv */
module wsc_accum #(
    parameter int NUM_PIXELS = 16384
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  wsc_pkg::item_t  in_item,
    input  wsc_pkg::cfg_t   cfg,
    output logic            busy,
    output logic            rd_valid,
    output wsc_pkg::rd_in_t rd_data
);
    import wsc_pkg::*;

    localparam int AW = $clog2(NUM_PIXELS);
    localparam logic [DST_W-1:0] NPIX = DST_W'(NUM_PIXELS);

    typedef struct packed {
        logic acc;
        logic clr;
        logic rd;
        logic inrange;
    } ctl_t;

    typedef struct packed {
        logic [13:0]        idx;
        logic [AW-1:0]      addr;
        logic signed [40:0] pf;
        logic [31:0]        pe;
        logic [23:0]        pq;
        logic [23:0]        cnt;
        logic signed [23:0] wts;
        logic signed [23:0] bkg;
    } dat_t;

    // stage 1: registered item
    logic  p1_valid_reg;
    item_t p1_reg;
    // stage 2: products, memory read issued
    ctl_t  p2_ctl_reg;
    dat_t  p2_reg;
    // stage 3: read data back, sums written
    ctl_t        p3_ctl_reg;
    dat_t        p3_reg;
    logic [63:0] p3_sq_reg;

    logic [AW-1:0] clr_addr_reg;
    logic          clr_busy_reg;

    logic          lw_valid_reg;
    logic [AW-1:0] lw_addr_reg;
    mem_t          lw_data_reg;

    logic [DST_W-1:0] n;
    logic [DST_W-1:0] dest;
    logic             src_ok;
    logic             dst_ok;
    logic             st_ok;
    ctl_t             s1_ctl;
    dat_t             s1_dat;

    mem_t          rdata;
    mem_t          cur;
    mem_t          upd;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    mem_t          mem_wdata;

    logic [24:0] exp25;
    logic [48:0] f49;
    logic [64:0] v65;
    logic [32:0] c33;
    logic [32:0] w33;
    logic [32:0] b33;
    logic [32:0] q33;

    assign busy = clr_busy_reg;

    // ---- stage 1: range, status and products
    always_comb begin
        n      = (DST_W'(cfg.pixel_count) < NPIX) ? DST_W'(cfg.pixel_count) : NPIX;
        dest   = DST_W'(p1_reg.idx) + {{(DST_W-15){cfg.shift[14]}}, cfg.shift};
        src_ok = DST_W'(p1_reg.idx) < n;
        dst_ok = !dest[DST_W-1] && (dest < n);
        if (cfg.status < 0) begin
            st_ok = 1'b0;
        end else if (cfg.status > 0) begin
            st_ok = cfg.accept_pos;
        end else begin
            st_ok = 1'b1;
        end
        s1_ctl.acc = p1_valid_reg && (p1_reg.cmd == CMD_ACCUM) && src_ok && dst_ok
                     && (p1_reg.qual != 8'd0) && (cfg.exposure != 16'd0) && st_ok;
        s1_ctl.clr     = p1_valid_reg && (p1_reg.cmd == CMD_CLEAR) && src_ok;
        s1_ctl.rd      = p1_valid_reg && (p1_reg.cmd == CMD_READ);
        s1_ctl.inrange = src_ok;
        s1_dat.idx  = p1_reg.idx;
        s1_dat.addr = (p1_reg.cmd == CMD_ACCUM) ? AW'(dest) : AW'(p1_reg.idx);
        s1_dat.pf   = $signed({1'b0, cfg.exposure}) * p1_reg.flux;
        s1_dat.pe   = cfg.exposure * p1_reg.err;
        s1_dat.pq   = cfg.exposure * p1_reg.qual;
        s1_dat.cnt  = p1_reg.cnt;
        s1_dat.wts  = p1_reg.wts;
        s1_dat.bkg  = p1_reg.bkg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_ctl_reg   <= '0;
            p3_ctl_reg   <= '0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            lw_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= in_valid;
            p2_ctl_reg   <= s1_ctl;
            p3_ctl_reg   <= p2_ctl_reg;
            lw_valid_reg <= mem_we;
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(NUM_PIXELS - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        p1_reg      <= in_item;
        p2_reg      <= s1_dat;
        p3_reg      <= p2_reg;
        p3_sq_reg   <= 64'(p2_reg.pe) * 64'(p2_reg.pe);
        lw_addr_reg <= mem_waddr;
        lw_data_reg <= mem_wdata;
    end

    wsc_ram #(
        .WIDTH ($bits(mem_t)),
        .DEPTH (NUM_PIXELS)
    ) u_sum_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (p2_reg.addr),
        .rdata (rdata)
    );

    // ---- stage 3: forward last write, saturating sums
    always_comb begin
        cur = (lw_valid_reg && (lw_addr_reg == p3_reg.addr)) ? lw_data_reg : rdata;

        exp25 = {1'b0, cur.exp_sum} + 25'(cfg.exposure);
        upd.exp_sum = exp25[24] ? 24'hFFFFFF : exp25[23:0];

        f49 = {cur.flux_sum[47], cur.flux_sum} + {{8{p3_reg.pf[40]}}, p3_reg.pf};
        if (f49[48] != f49[47]) begin
            upd.flux_sum = f49[48] ? 48'h800000000000 : 48'h7FFFFFFFFFFF;
        end else begin
            upd.flux_sum = f49[47:0];
        end

        v65 = {1'b0, cur.var_sum} + {1'b0, p3_sq_reg};
        upd.var_sum = v65[64] ? '1 : v65[63:0];

        c33 = {1'b0, cur.cnt_sum} + 33'(p3_reg.cnt);
        upd.cnt_sum = c33[32] ? '1 : c33[31:0];

        w33 = {cur.wts_sum[31], cur.wts_sum} + {{9{p3_reg.wts[23]}}, p3_reg.wts};
        if (w33[32] != w33[31]) begin
            upd.wts_sum = w33[32] ? 32'h80000000 : 32'h7FFFFFFF;
        end else begin
            upd.wts_sum = w33[31:0];
        end

        b33 = {cur.bkg_sum[31], cur.bkg_sum} + {{9{p3_reg.bkg[23]}}, p3_reg.bkg};
        if (b33[32] != b33[31]) begin
            upd.bkg_sum = b33[32] ? 32'h80000000 : 32'h7FFFFFFF;
        end else begin
            upd.bkg_sum = b33[31:0];
        end

        q33 = {1'b0, cur.qual_sum} + 33'(p3_reg.pq);
        upd.qual_sum = q33[32] ? '1 : q33[31:0];

        if (clr_busy_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = p3_ctl_reg.acc || p3_ctl_reg.clr;
            mem_waddr = p3_reg.addr;
            mem_wdata = p3_ctl_reg.acc ? upd : '0;
        end

        rd_valid     = p3_ctl_reg.rd;
        rd_data.idx  = p3_reg.idx;
        rd_data.sums = p3_ctl_reg.inrange ? cur : '0;
    end

endmodule

/* hdl/wsc_readout.sv */
module wsc_readout (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  wsc_pkg::rd_in_t in_data,
    output logic            out_valid,
    output wsc_pkg::out_t   out_data
);
    import wsc_pkg::*;

    typedef struct packed {
        logic [13:0] idx;
        logic [23:0] e;
        logic [47:0] fs;
        logic [63:0] v;
        logic [31:0] cnt;
        logic [31:0] wts;
        logic [31:0] bkg;
        logic [31:0] qsum;
        logic        fneg;
        logic [48:0] fnum;
        logic [23:0] fq;
        logic        fovf;
        logic [33:0] qnum;
        logic [7:0]  qq;
        logic        qovf;
        logic [33:0] srem;
        logic [31:0] sroot;
        logic [31:0] erem;
        logic [15:0] eq;
        logic        eovf;
        logic [40:0] tprod;
        logic        big;
        logic [63:0] prod;
        logic [23:0] mf;
        logic [15:0] me;
        logic [7:0]  mq;
    } rs_t;

    // Stage map: 1 numerators, sqrt 1..16 (two root bits a stage), 2 overflow
    // checks, 3..14 flux quotient, 3..6 quality quotient, 17 error overflow,
    // 18..25 error quotient, 26..28 rounding test for the error and output.
    function automatic rs_t rd_stage(input int k, input rs_t si);
        rs_t         s;
        int          b;
        int          i;
        logic [47:0] mag;
        logic [48:0] fd;
        logic [33:0] qd;
        logic [39:0] ed;
        logic [33:0] trial;
        logic [64:0] lim;
        logic        up;
        logic [16:0] qe;
        s = si;
        if (k == 1) begin
            s.fneg  = s.fs[47];
            mag     = s.fs[47] ? (~s.fs + 48'd1) : s.fs;
            s.fnum  = {mag, 1'b0} + 49'(s.e);
            s.qnum  = {1'b0, s.qsum, 1'b0} + 34'(s.e);
            s.srem  = '0;
            s.sroot = '0;
        end
        if (k >= 1 && k <= 16) begin
            for (int j = 0; j < 2; j++) begin
                i      = 31 - 2 * (k - 1) - j;
                s.srem = {s.srem[31:0], s.v[2*i+1 -: 2]};
                trial  = {s.sroot, 2'b01};
                if (s.srem >= trial) begin
                    s.srem  = s.srem - trial;
                    s.sroot = {s.sroot[30:0], 1'b1};
                end else begin
                    s.sroot = {s.sroot[30:0], 1'b0};
                end
            end
        end
        if (k == 2) begin
            fd     = 49'({s.e, 1'b0}) << 24;
            s.fovf = s.fnum >= fd;
            s.fq   = '0;
            qd     = 34'({s.e, 1'b0}) << 8;
            s.qovf = s.qnum >= qd;
            s.qq   = '0;
        end
        if (k >= 3 && k <= 14) begin
            for (int j = 0; j < 2; j++) begin
                b  = 23 - 2 * (k - 3) - j;
                fd = 49'({s.e, 1'b0}) << b;
                if (s.fnum >= fd) begin
                    s.fnum  = s.fnum - fd;
                    s.fq[b] = 1'b1;
                end
            end
        end
        if (k >= 3 && k <= 6) begin
            for (int j = 0; j < 2; j++) begin
                b  = 7 - 2 * (k - 3) - j;
                qd = 34'({s.e, 1'b0}) << b;
                if (s.qnum >= qd) begin
                    s.qnum  = s.qnum - qd;
                    s.qq[b] = 1'b1;
                end
            end
        end
        if (k == 17) begin
            ed     = 40'(s.e) << 16;
            s.eovf = {8'd0, s.sroot} >= ed;
            s.erem = s.sroot;
            s.eq   = '0;
        end
        if (k >= 18 && k <= 25) begin
            for (int j = 0; j < 2; j++) begin
                b  = 15 - 2 * (k - 18) - j;
                ed = 40'(s.e) << b;
                if ({8'd0, s.erem} >= ed) begin
                    s.erem  = s.erem - ed[31:0];
                    s.eq[b] = 1'b1;
                end
            end
        end
        if (k == 26) begin
            s.tprod = {s.eq, 1'b1} * s.e;
        end
        if (k == 27) begin
            s.big  = |s.tprod[40:33];
            s.prod = 64'(s.tprod[32:1]) * 64'(s.tprod[32:1]);
        end
        if (k == 28) begin
            // odd exposure: compare against a*(a+1), even: against u*u
            lim = s.e[0] ? (65'(s.prod) + 65'(s.tprod[32:1])) : 65'(s.prod);
            up  = !s.big && (s.e[0] ? (65'(s.v) > lim) : (65'(s.v) >= lim));
            qe  = 17'(s.eq) + 17'(up);
            s.me = (s.eovf || (qe > 17'd65535)) ? 16'hFFFF : qe[15:0];
            if (s.fneg) begin
                s.mf = (s.fovf || (s.fq > 24'd8388608)) ? 24'h800000 : (~s.fq + 24'd1);
            end else begin
                s.mf = (s.fovf || (s.fq > 24'd8388607)) ? 24'h7FFFFF : s.fq;
            end
            s.mq = s.qovf ? 8'hFF : s.qq;
            if (s.e == 24'd0) begin
                s.mf = '0;
                s.me = '0;
                s.mq = '0;
            end
        end
        return s;
    endfunction

    rs_t              st_reg [RD_STAGES+1];
    logic [RD_STAGES:0] vld_reg;
    rs_t              s0;

    always_comb begin
        s0      = '0;
        s0.idx  = in_data.idx;
        s0.e    = in_data.sums.exp_sum;
        s0.fs   = in_data.sums.flux_sum;
        s0.v    = in_data.sums.var_sum;
        s0.cnt  = in_data.sums.cnt_sum;
        s0.wts  = in_data.sums.wts_sum;
        s0.bkg  = in_data.sums.bkg_sum;
        s0.qsum = in_data.sums.qual_sum;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[RD_STAGES-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        st_reg[0] <= s0;
        for (int k = 1; k <= RD_STAGES; k++) begin
            st_reg[k] <= rd_stage(k, st_reg[k-1]);
        end
    end

    assign out_valid                 = vld_reg[RD_STAGES];
    assign out_data.out_index        = st_reg[RD_STAGES].idx;
    assign out_data.mean_flux        = st_reg[RD_STAGES].mf;
    assign out_data.mean_error       = st_reg[RD_STAGES].me;
    assign out_data.mean_quality     = st_reg[RD_STAGES].mq;
    assign out_data.total_counts     = st_reg[RD_STAGES].cnt;
    assign out_data.total_weights    = st_reg[RD_STAGES].wts;
    assign out_data.total_background = st_reg[RD_STAGES].bkg;
    assign out_data.total_exposure   = st_reg[RD_STAGES].e;

endmodule
